// ===== hw/rtl/hmtp_pkg.sv =====
// Shared types, constants and helpers of the height map text parser.
package hmtp_pkg;

  localparam int TEXT_W   = 8;
  localparam int DIM_W    = 13;
  localparam int COORD_W  = 12;
  localparam int HEIGHT_W = 32;
  localparam int COLOR_W  = 24;
  localparam int THR_W    = 34;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int OUT_W    = 2 * COORD_W + HEIGHT_W + COLOR_W;

  // Grid limits; the counter widths above are sized for them
  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  // Divide a 32-bit magnitude by five: multiply, then keep bits from FIFTH_SHIFT up
  localparam logic [HEIGHT_W-1:0] FIFTH_RECIP = 32'hCCCC_CCCD;
  localparam int                  FIFTH_SHIFT = 34;

  // Number of prefix characters still to skip once the first one is seen
  localparam logic [1:0] PREFIX_REST = 2'd2;

  localparam logic [TEXT_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [TEXT_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [TEXT_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [TEXT_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [TEXT_W-1:0] CH_NINE    = 8'h39;
  localparam logic [TEXT_W-1:0] CH_LOW_A   = 8'h61;
  localparam logic [TEXT_W-1:0] CH_LOW_F   = 8'h66;
  localparam logic [TEXT_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [TEXT_W-1:0] CH_UP_F    = 8'h46;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DIGITS = 3'd1,
    PH_SCAN   = 3'd2,
    PH_PREFIX = 3'd3,
    PH_HEX    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH    = 3'd0,
    REG_MAP_ROWS     = 3'd1,
    REG_LO_BOUND     = 3'd2,
    REG_HI_BOUND     = 3'd3,
    REG_HI_SHADE     = 3'd4,
    REG_MIDDLE_COLOR = 3'd5,
    REG_LO_SHADE     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0]         column;
    logic [COORD_W-1:0]         row_index;
    logic signed [HEIGHT_W-1:0] height;
    logic [COLOR_W-1:0]         color;
    logic                       has_color;
    logic                       last;
  } point_t;

  function automatic logic [3:0] hex_value(input logic [TEXT_W-1:0] c);
    logic [TEXT_W-1:0] t;
    begin
      t = 8'h00;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        t = c - CH_ZERO;
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
        t = c - CH_LOW_A + 8'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
        t = c - CH_UP_A + 8'd10;
      end
      return t[3:0];
    end
  endfunction

endpackage

// ===== hw/rtl/hmtp_parser.sv =====
// Token parser and grid position counters of the height map text parser.
module hmtp_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [hmtp_pkg::TEXT_W-1:0]   text_byte,
  input  logic                          end_of_text,
  input  logic [hmtp_pkg::DIM_W-1:0]    eff_w,
  input  logic [hmtp_pkg::DIM_W-1:0]    eff_r,
  output logic                          emit,
  output hmtp_pkg::point_t              pt
);
  import hmtp_pkg::*;

  phase_t              phase_r, phase_nxt, tok_phase;
  logic                neg_r, neg_nxt, tok_neg;
  logic [HEIGHT_W-1:0] hacc_r, hacc_nxt, tok_h;
  logic [COLOR_W-1:0]  cacc_r, cacc_nxt, tok_c;
  logic                hasc_r, hasc_nxt, tok_hasc;
  logic [1:0]          skip_r, skip_nxt, tok_skip;
  logic [DIM_W-1:0]    col_r, col_nxt, row_r, row_nxt;
  logic                done_r, done_nxt;

  logic                is_sep, is_digit, is_minus, finish, in_grid;
  logic [3:0]          digit_val;
  logic [DIM_W:0]      col_inc, row_inc;
  logic [HEIGHT_W-1:0] height_val;

  assign is_sep    = (text_byte == CH_SPACE) || (text_byte == CH_NEWLINE);
  assign is_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_minus  = (text_byte == CH_MINUS);
  assign digit_val = text_byte[3:0];
  assign finish    = is_sep ? (phase_r != PH_IDLE) : end_of_text;

  // Next phase within the token, before finishing.
  always_comb begin
    tok_phase = phase_r;
    if (!is_sep) begin
      unique case (phase_r)
        PH_IDLE:   tok_phase = (is_minus || is_digit) ? PH_DIGITS : PH_PREFIX;
        PH_DIGITS: begin
          if (is_digit)      tok_phase = PH_DIGITS;
          else if (is_minus) tok_phase = PH_SCAN;
          else               tok_phase = PH_PREFIX;
        end
        PH_SCAN:   tok_phase = (!is_digit && !is_minus) ? PH_PREFIX : PH_SCAN;
        PH_PREFIX: tok_phase = (skip_r == 2'd1) ? PH_HEX : PH_PREFIX;
        PH_HEX:    tok_phase = PH_HEX;
        default:   tok_phase = PH_IDLE;
      endcase
    end
    phase_nxt = (finish || end_of_text) ? PH_IDLE : tok_phase;
  end

  // Accumulators and grid position.
  always_comb begin
    tok_neg  = neg_r;
    tok_h    = hacc_r;
    tok_c    = cacc_r;
    tok_hasc = hasc_r;
    tok_skip = skip_r;
    if (!is_sep) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (is_minus) begin
            tok_neg = 1'b1;
          end else if (is_digit) begin
            tok_h = {28'd0, digit_val};
          end else begin
            tok_hasc = 1'b1;
            tok_c    = '0;
            tok_skip = PREFIX_REST;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            tok_h = (hacc_r << 3) + (hacc_r << 1) + {28'd0, digit_val};
          end else if (!is_minus) begin
            tok_hasc = 1'b1;
            tok_c    = '0;
            tok_skip = PREFIX_REST;
          end
        end
        PH_SCAN: begin
          if (!is_digit && !is_minus) begin
            tok_hasc = 1'b1;
            tok_c    = '0;
            tok_skip = PREFIX_REST;
          end
        end
        PH_PREFIX: tok_skip = skip_r - 2'd1;
        PH_HEX:    tok_c = {cacc_r[COLOR_W-5:0], hex_value(text_byte)};
        default:   tok_skip = skip_r;
      endcase
    end

    height_val = tok_neg ? (32'd0 - tok_h) : tok_h;
    in_grid    = !done_r && (col_r < eff_w) && (row_r < eff_r);
    col_inc    = {1'b0, col_r} + 14'd1;
    row_inc    = {1'b0, row_r} + 14'd1;

    emit          = accept && finish && in_grid;
    pt.column     = col_r[COORD_W-1:0];
    pt.row_index  = row_r[COORD_W-1:0];
    pt.height     = height_val;
    pt.color      = tok_c;
    pt.has_color  = tok_hasc;
    pt.last       = (col_inc == {1'b0, eff_w}) && (row_inc == {1'b0, eff_r});

    col_nxt  = col_r;
    row_nxt  = row_r;
    done_nxt = done_r;
    if (finish && !done_r) begin
      if (col_inc >= {1'b0, eff_w}) begin
        col_nxt = '0;
        row_nxt = row_inc[DIM_W-1:0];
        if (row_inc >= {1'b0, eff_r}) done_nxt = 1'b1;
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end

    neg_nxt  = tok_neg;
    hacc_nxt = tok_h;
    cacc_nxt = tok_c;
    hasc_nxt = tok_hasc;
    skip_nxt = tok_skip;
    if (finish || end_of_text) begin
      neg_nxt  = 1'b0;
      hacc_nxt = '0;
      cacc_nxt = '0;
      hasc_nxt = 1'b0;
      skip_nxt = '0;
    end
    // end of text starts a new map
    if (end_of_text) begin
      col_nxt  = '0;
      row_nxt  = '0;
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      neg_r   <= 1'b0;
      hacc_r  <= '0;
      cacc_r  <= '0;
      hasc_r  <= 1'b0;
      skip_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      done_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      hacc_r  <= hacc_nxt;
      cacc_r  <= cacc_nxt;
      hasc_r  <= hasc_nxt;
      skip_r  <= skip_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

// ===== hw/rtl/hmtp_thresh.sv =====
// Color threshold unit: one fifth of the height span by reciprocal multiplication.
module hmtp_thresh (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [hmtp_pkg::HEIGHT_W-1:0] lo_bound,
  input  logic signed [hmtp_pkg::HEIGHT_W-1:0] hi_bound,
  output logic                                busy,
  output logic signed [hmtp_pkg::THR_W-1:0]   thr_top,
  output logic signed [hmtp_pkg::THR_W-1:0]   thr_bot
);
  import hmtp_pkg::*;

  logic                       pend_r, mul_r, fin_r, neg_r;
  logic [HEIGHT_W-1:0]        mag_r;
  logic [2*HEIGHT_W-1:0]      prod_r;
  logic signed [THR_W-1:0]    top_r, bot_r;

  logic signed [HEIGHT_W:0]   span;
  logic [HEIGHT_W:0]          span_mag;
  logic [2*HEIGHT_W-1:0]      prod_nxt;
  logic [HEIGHT_W-1:0]        quo;
  logic signed [THR_W-1:0]    fifth, lo_x, hi_x;

  assign span     = {hi_bound[HEIGHT_W-1], hi_bound} - {lo_bound[HEIGHT_W-1], lo_bound};
  assign span_mag = span[HEIGHT_W] ? (33'd0 - span) : span;
  assign prod_nxt = {{HEIGHT_W{1'b0}}, mag_r} * {{HEIGHT_W{1'b0}}, FIFTH_RECIP};
  assign quo      = {2'b00, prod_r[2*HEIGHT_W-1:FIFTH_SHIFT]};
  assign fifth    = neg_r ? (34'sd0 - $signed({2'b00, quo})) : $signed({2'b00, quo});
  assign lo_x     = {{2{lo_bound[HEIGHT_W-1]}}, lo_bound};
  assign hi_x     = {{2{hi_bound[HEIGHT_W-1]}}, hi_bound};

  assign busy    = pend_r || mul_r || fin_r;
  assign thr_top = top_r;
  assign thr_bot = bot_r;

  // Three steps: capture the span, multiply, apply the fifth to both ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      mul_r  <= 1'b0;
      fin_r  <= 1'b0;
      top_r  <= '0;
      bot_r  <= '0;
    end else begin
      pend_r <= start;
      mul_r  <= pend_r;
      fin_r  <= mul_r;
      if (fin_r) begin
        top_r <= hi_x - fifth;
        bot_r <= lo_x + fifth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      mag_r <= span_mag[HEIGHT_W-1:0];
      neg_r <= span[HEIGHT_W];
    end
    if (mul_r) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== hw/rtl/height_map_text_parser_top.sv =====
// Top level of the height map text parser: config registers, parser and output pipeline.
//
// The block reads map text one byte per request on the in_ stream and emits
// one point per finished token on the out_ stream. Space and newline split
// tokens; a token is a signed decimal height, optionally followed by a
// three-character prefix and hex color digits. Points carry column, row,
// height and color; without a suffix the color is picked from the height
// against thresholds one fifth of the height span from each end. The input
// takes one byte every cycle while in_tready is high; the point of the byte
// that finishes its token is registered in the point register, gets its color
// combinationally from there and is registered in the output register, and a
// stalled output only holds the input once both stages are full. After a write
// to either height bound, in_tready drops while the threshold unit divides the
// span by five with a reciprocal multiply (capture, multiply, apply); other register writes take
// effect at once. The last byte of the text (in_tlast) finishes its token and
// rewinds the grid to the origin for the next map. Tokens beyond the grid are
// dropped. Registers sit at byte addresses 4*i in the order: row width, row
// count, low height bound, high height bound, color near the high bound,
// middle color, color near the low bound.
module height_map_text_parser_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,     // [7:0] text_byte
  input  logic                          in_tlast,     // end_of_text
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hmtp_pkg::OUT_W-1:0]    out_tdata,    // [11:0] column, [23:12] row_index,
                                                      // [55:24] height, [79:56] point_color
  output logic                          out_tlast,    // last_point
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [hmtp_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [hmtp_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [hmtp_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import hmtp_pkg::*;

  localparam logic [16:0] MAX_C = 17'(MAX_COLUMNS);
  localparam logic [16:0] MAX_R = 17'(MAX_ROWS);

  // Configuration registers
  logic [DIM_W-1:0]           map_width_r, map_rows_r;
  logic signed [HEIGHT_W-1:0] lo_bound_r, hi_bound_r;
  logic [COLOR_W-1:0]         hi_shade_r, middle_color_r, lo_shade_r;

  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;
  logic [DIM_W-1:0]           eff_w, eff_r;

  // Pipeline
  logic                       accept, emit;
  point_t                     pt;
  point_t                     s1_r;
  logic                       s1_valid_r, s1_valid_nxt, s1_free, s2_free;
  logic                       out_valid_r;
  logic [OUT_W-1:0]           out_data_r;
  logic                       out_last_r;

  // Threshold unit
  logic                       thr_busy, thr_start;
  logic signed [THR_W-1:0]    thr_top, thr_bot;
  logic signed [THR_W-1:0]    h_x;
  logic [COLOR_W-1:0]         color_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign thr_start  = cfg_wr && (cfg_idx == REG_LO_BOUND || cfg_idx == REG_HI_BOUND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r    <= 13'd1;
      map_rows_r     <= 13'd1;
      lo_bound_r     <= '0;
      hi_bound_r     <= '0;
      hi_shade_r     <= '0;
      middle_color_r <= '0;
      lo_shade_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAP_WIDTH:    map_width_r    <= cfg_pwdata[DIM_W-1:0];
        REG_MAP_ROWS:     map_rows_r     <= cfg_pwdata[DIM_W-1:0];
        REG_LO_BOUND:     lo_bound_r     <= cfg_pwdata;
        REG_HI_BOUND:     hi_bound_r     <= cfg_pwdata;
        REG_HI_SHADE:     hi_shade_r     <= cfg_pwdata[COLOR_W-1:0];
        REG_MIDDLE_COLOR: middle_color_r <= cfg_pwdata[COLOR_W-1:0];
        REG_LO_SHADE:     lo_shade_r     <= cfg_pwdata[COLOR_W-1:0];
        default:          map_width_r    <= map_width_r;  // drop writes past the list
      endcase
    end
  end

  // Read back the register at the addressed slot.
  always_comb begin
    unique case (cfg_idx)
      REG_MAP_WIDTH:    cfg_prdata = {19'd0, map_width_r};
      REG_MAP_ROWS:     cfg_prdata = {19'd0, map_rows_r};
      REG_LO_BOUND:     cfg_prdata = lo_bound_r;
      REG_HI_BOUND:     cfg_prdata = hi_bound_r;
      REG_HI_SHADE:     cfg_prdata = {8'd0, hi_shade_r};
      REG_MIDDLE_COLOR: cfg_prdata = {8'd0, middle_color_r};
      REG_LO_SHADE:     cfg_prdata = {8'd0, lo_shade_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // Zero acts as one, and anything above the grid limit acts as the limit.
  always_comb begin
    if (map_width_r == '0)               eff_w = 13'd1;
    else if ({4'd0, map_width_r} > MAX_C) eff_w = MAX_C[DIM_W-1:0];
    else                                 eff_w = map_width_r;
    if (map_rows_r == '0)                eff_r = 13'd1;
    else if ({4'd0, map_rows_r} > MAX_R)  eff_r = MAX_R[DIM_W-1:0];
    else                                 eff_r = map_rows_r;
  end

  hmtp_thresh u_thresh (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (thr_start),
    .lo_bound (lo_bound_r),
    .hi_bound (hi_bound_r),
    .busy     (thr_busy),
    .thr_top  (thr_top),
    .thr_bot  (thr_bot)
  );

  // Flow control: the output register frees when taken, the point register
  // frees when it moves on; hold the input while thresholds are recomputed.
  assign s2_free   = !out_valid_r || out_tready;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_tready = !thr_busy && s1_free;
  assign accept    = in_tvalid && in_tready;

  hmtp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .eff_w       (eff_w),
    .eff_r       (eff_r),
    .emit        (emit),
    .pt          (pt)
  );

  assign s1_valid_nxt = s1_free ? emit : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && emit) begin
      s1_r <= pt;
    end
  end

  // Suffix color if present; else top band first, then bottom band, else middle.
  always_comb begin
    h_x = {{2{s1_r.height[HEIGHT_W-1]}}, s1_r.height};
    if (s1_r.has_color)    color_sel = s1_r.color;
    else if (h_x >= thr_top) color_sel = hi_shade_r;
    else if (h_x <= thr_bot) color_sel = lo_shade_r;
    else                   color_sel = middle_color_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      out_data_r <= {color_sel, s1_r.height, s1_r.row_index, s1_r.column};
      out_last_r <= s1_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/hmtp_checker.sv =====
// Port-level checks of the height map text parser and their binding.
module hmtp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [hmtp_pkg::OUT_W-1:0]  out_tdata,
  input logic                        out_tlast,
  input logic                        cfg_psel,
  input logic                        cfg_penable,
  input logic                        cfg_pwrite,
  input logic [hmtp_pkg::ADDR_W-1:0] cfg_paddr
);
  import hmtp_pkg::*;

  // Hold a stalled point.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled point changed");

  // Drop any pending point on reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("point shown right after reset");

  // A fresh point comes from a request that passed the point register and then the output register.
  a_point_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && $past(rst_n) && $past(rst_n, 2) |-> $past(in_tvalid && in_tready, 2))
    else $error("point without a matching request");

  // Hold the input while the thresholds are recomputed.
  a_thresh_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite &&
    (cfg_paddr[ADDR_W-1:2] == REG_LO_BOUND || cfg_paddr[ADDR_W-1:2] == REG_HI_BOUND)
    |=> !in_tready)
    else $error("input open during threshold update");

endmodule

bind height_map_text_parser_top hmtp_checker u_hmtp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tlast   (out_tlast),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr)
);

// ===== tb/sv/tb_height_map_text_parser_top.sv =====
// Self-checking testbench for the height map text parser top level.
`timescale 1ns / 1ps

module tb_height_map_text_parser_top;
  import hmtp_pkg::*;

  localparam int SETTLE       = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_BYTES  = 250;
  localparam int NUM_PHASES   = 6;

  // ---------------------------------------------------------------------------
  // Point tracker: follows the parser byte by byte and keeps the points it
  // expects to see on the result stream, oldest first.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row_index;
    logic [HEIGHT_W-1:0] height;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } map_point_t;

  class point_tracker;
    logic [DIM_W-1:0]           width_reg, rows_reg;
    logic signed [HEIGHT_W-1:0] min_h, max_h;
    logic [COLOR_W-1:0]         top_c, mid_c, bot_c;

    phase_t              ph;
    bit                  neg;
    logic [HEIGHT_W-1:0] h_acc;
    logic [COLOR_W-1:0]  c_acc;
    bit                  has_c;
    logic [1:0]          skip;
    int unsigned         col_cnt, row_cnt;
    bit                  grid_full;

    map_point_t pending_points[$];
    int errors;
    int points_checked;

    function new();
      width_reg = 1;
      rows_reg  = 1;
      min_h = 0;
      max_h = 0;
      top_c = 0;
      mid_c = 0;
      bot_c = 0;
      clear_token();
      col_cnt = 0;
      row_cnt = 0;
      grid_full = 0;
      errors = 0;
      points_checked = 0;
    endfunction

    function void clear_token();
      ph    = PH_IDLE;
      neg   = 0;
      h_acc = 0;
      c_acc = 0;
      has_c = 0;
      skip  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_MAP_WIDTH:    width_reg = v[DIM_W-1:0];
        REG_MAP_ROWS:     rows_reg  = v[DIM_W-1:0];
        REG_LO_BOUND:     min_h     = v;
        REG_HI_BOUND:     max_h     = v;
        REG_HI_SHADE:     top_c     = v[COLOR_W-1:0];
        REG_MIDDLE_COLOR: mid_c     = v[COLOR_W-1:0];
        REG_LO_SHADE:     bot_c     = v[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function logic [3:0] nibble_of(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return c[3:0];
      if ((c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F))
        return c[3:0] + 4'd9;
      return 4'd0;
    endfunction

    // Height-derived color with thresholds one fifth of the span from each end
    function logic [COLOR_W-1:0] shade_of(logic [HEIGHT_W-1:0] h);
      longint lo, hi, d, v;
      lo = min_h;
      hi = max_h;
      d  = (hi - lo) / 5;
      v  = longint'($signed(h));
      if (v >= hi - d) return top_c;
      if (v <= lo + d) return bot_c;
      return mid_c;
    endfunction

    function void open_suffix();
      ph    = PH_PREFIX;
      has_c = 1;
      c_acc = 0;
      skip  = PREFIX_REST;
    endfunction

    function void close_token();
      int unsigned w, r;
      logic [HEIGHT_W-1:0] h;
      map_point_t p;
      w = clamp_dim(width_reg, MAX_COLUMNS);
      r = clamp_dim(rows_reg, MAX_ROWS);
      h = neg ? -h_acc : h_acc;
      if (!grid_full && col_cnt < w && row_cnt < r) begin
        p.column    = col_cnt[COORD_W-1:0];
        p.row_index = row_cnt[COORD_W-1:0];
        p.height    = h;
        p.color     = has_c ? c_acc : shade_of(h);
        p.last      = (col_cnt + 1 == w) && (row_cnt + 1 == r);
        pending_points.push_back(p);
      end
      if (!grid_full) begin
        col_cnt++;
        if (col_cnt >= w) begin
          col_cnt = 0;
          row_cnt++;
          if (row_cnt >= r) grid_full = 1;
        end
      end
      clear_token();
    endfunction

    // Note one accepted text byte
    function void take_byte(logic [7:0] c, bit eot);
      bit sep, dig;
      sep = (c == CH_SPACE) || (c == CH_NEWLINE);
      dig = (c >= CH_ZERO) && (c <= CH_NINE);
      if (sep) begin
        if (ph != PH_IDLE) close_token();
      end else begin
        case (ph)
          PH_IDLE: begin
            if (c == CH_MINUS) begin
              neg = 1;
              ph  = PH_DIGITS;
            end else if (dig) begin
              h_acc = c - CH_ZERO;
              ph    = PH_DIGITS;
            end else begin
              open_suffix();
            end
          end
          PH_DIGITS: begin
            if (dig) h_acc = h_acc * 10 + (c - CH_ZERO);
            else if (c == CH_MINUS) ph = PH_SCAN;
            else open_suffix();
          end
          PH_SCAN: begin
            if (!dig && c != CH_MINUS) open_suffix();
          end
          PH_PREFIX: begin
            skip = skip - 2'd1;
            if (skip == 0) ph = PH_HEX;
          end
          default: c_acc = {c_acc[COLOR_W-5:0], nibble_of(c)};
        endcase
        if (eot) close_token();
      end
      if (eot) begin
        clear_token();
        col_cnt   = 0;
        row_cnt   = 0;
        grid_full = 0;
      end
    endfunction

    function void report(string what, logic [HEIGHT_W-1:0] e, logic [HEIGHT_W-1:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, e, a);
        errors++;
      end
    endfunction

    // Compare one accepted point against the oldest expectation
    function void check_point(logic [OUT_W-1:0] d, logic lastb);
      map_point_t p;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, got data 0x%0h last %0b",
                 $time, d, lastb);
        errors++;
        return;
      end
      p = pending_points.pop_front();
      points_checked++;
      report("column",      p.column,    d[11:0]);
      report("row_index",   p.row_index, d[23:12]);
      report("height",      p.height,    d[55:24]);
      report("point_color", p.color,     d[79:56]);
      report("last_point",  p.last,      lastb);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata  = '0;
  logic              in_tlast  = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  height_map_text_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  point_tracker pts;
  bit tx_burst = 0;   // no gaps between input requests while set
  bit rx_burst = 0;   // no stalls on the result side while set
  int cycles = 0;
  int bytes_sent = 0;
  int settings = 0;
  logic [7:0] text_q[$];
  bit         eot_q[$];

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d points still outstanding", $time,
               pts.pending_points.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: hold tready low for a random number of cycles per request
  initial begin : result_sink
    int n;
    @(posedge rst_n);
    forever begin
      n = rx_burst ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Check every accepted point
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) pts.check_point(out_tdata, out_tlast);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write one register: setup cycle, access cycle, then one idle bus cycle
  task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(4 * int'(idx));
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    pts.set_reg(idx, v);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    // a height bound restarts the threshold unit; hold off until it is done
    if (idx == REG_LO_BOUND || idx == REG_HI_BOUND) begin
      repeat (2) @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
  endtask

  task automatic program_map(logic [DATA_W-1:0] w, logic [DATA_W-1:0] r,
                             logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                             logic [DATA_W-1:0] tc, logic [DATA_W-1:0] mc,
                             logic [DATA_W-1:0] bc);
    apb_write(REG_MAP_WIDTH, w);
    apb_write(REG_MAP_ROWS, r);
    apb_write(REG_LO_BOUND, lo);
    apb_write(REG_HI_BOUND, hi);
    apb_write(REG_HI_SHADE, tc);
    apb_write(REG_MIDDLE_COLOR, mc);
    apb_write(REG_LO_SHADE, bc);
    settings++;
  endtask

  // Present one byte after a random gap and advance once the request is taken
  task automatic send_byte(logic [7:0] b, bit eot);
    int gap;
    if (bytes_sent % 64 == 0) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
    end
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pts.take_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic flush_text();
    while (text_q.size() > 0) send_byte(text_q.pop_front(), eot_q.pop_front());
  endtask

  // Drop tvalid and wait until every expected point has come out
  task automatic drain_points(bit settle);
    in_tvalid <= 1'b0;
    while (pts.pending_points.size() > 0) @(posedge clk);
    if (settle) repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------
  function automatic void push_char(logic [7:0] c);
    text_q.push_back(c);
    eot_q.push_back(1'b0);
  endfunction

  function automatic void push_digits(int n);
    for (int i = 0; i < n; i++) push_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void push_height();
    if ($urandom_range(0, 9) < 3) push_char(CH_MINUS);
    push_digits(($urandom_range(0, 19) == 0) ? $urandom_range(10, 12)
                                             : $urandom_range(1, 4));
  endfunction

  function automatic logic [7:0] any_non_sep();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_SPACE || c == CH_NEWLINE);
    return c;
  endfunction

  // First prefix character has to close the height: not a digit, minus or separator
  function automatic void push_prefix(int n);
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) begin
      c = ",";
    end else begin
      case ($urandom_range(0, 4))
        0: c = "+";
        1: c = "\t";
        2: c = 8'h00;
        3: c = ";";
        default: c = 8'($urandom_range(128, 255));
      endcase
    end
    push_char(c);
    if (n > 1) push_char((c == ",") ? "0" : any_non_sep());
    if (n > 2) push_char((c == ",") ? "x" : any_non_sep());
  endfunction

  function automatic void push_hex(int n);
    string digits;
    digits = "0123456789abcdefABCDEFgz!";
    for (int i = 0; i < n; i++) push_char(digits[$urandom_range(0, digits.len() - 1)]);
  endfunction

  // One token plus separators; mostly well formed, some short or broken
  function automatic void add_token();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      push_height();
    end else if (kind < 75) begin
      push_height();
      push_prefix(3);
      push_hex($urandom_range(0, 8));
    end else if (kind < 83) begin
      push_digits($urandom_range(1, 3));
      push_char(CH_MINUS);
      push_digits($urandom_range(0, 3));
    end else if (kind < 90) begin
      push_digits($urandom_range(0, 2));
      push_prefix($urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)));
    end
    // end of text lands on the token itself or on its separator
    if ($urandom_range(0, 39) == 0 && $urandom_range(0, 1) == 0) begin
      eot_q[eot_q.size() - 1] = 1'b1;
      return;
    end
    repeat ($urandom_range(1, 2)) push_char($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
    if ($urandom_range(0, 39) == 0) eot_q[eot_q.size() - 1] = 1'b1;
  endfunction

  function automatic void pick_bounds(output logic [DATA_W-1:0] lo,
                                      output logic [DATA_W-1:0] hi);
    case ($urandom_range(0, 5))
      0: begin lo = -32'sd5000;   hi = 32'sd5000;   end
      1: begin lo = 32'sd0;       hi = 32'sd9999;   end
      2: begin lo = 32'sd100;     hi = 32'sd100;    end
      3: begin lo = 32'sd3000;    hi = -32'sd3000;  end
      4: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
      default: begin lo = $urandom; hi = $urandom; end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    string directed;
    logic [DATA_W-1:0] w, r, lo, hi;
    bit paused;
    pts = new();
    paused = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 2x2 grid, leading and later minus, a lone tab, a mixed-case
    // suffix with a bad hex digit, a short suffix, tokens past the grid and
    // an end of text on a NUL/0xFF token.
    program_map(2, 2, -32'sd100, 32'sd100, 24'hFF0000, 24'h00FF00, 24'h0000FF);
    directed = "-7 5-3 \t 9+0xAb1Fg ,0 ";
    for (int i = 0; i < directed.len(); i++) push_char(directed[i]);
    push_char(8'h00);
    text_q.push_back(8'hFF);
    eot_q.push_back(1'b1);
    flush_text();
    drain_points(1);

    for (int p = 1; p <= NUM_PHASES; p++) begin
      case (p)
        1: begin w = 8191; r = 0;    end   // clamp to widest row, single row
        2: begin w = 0;    r = 8191; end   // one point per row, clamp rows
        3: begin w = 4096; r = 4096; end
        default: begin
          w = $urandom_range(1, 6);
          r = $urandom_range(1, 5);
        end
      endcase
      pick_bounds(lo, hi);
      if (p == 3) begin
        program_map(w, r, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
      end else begin
        program_map(w, r, lo, hi, $urandom, $urandom, $urandom);
      end

      while (bytes_sent < 24 + p * PHASE_BYTES) begin
        add_token();
        flush_text();
        // pause the sender until the result stream has caught up
        if ((!paused && bytes_sent >= 24 + PHASE_BYTES / 2) || $urandom_range(0, 99) == 0) begin
          drain_points(0);
          paused = 1;
        end
      end
      drain_points(1);
    end

    $display("summary: %0d text bytes over %0d register settings, %0d points checked",
             bytes_sent, settings, pts.points_checked);
    if (pts.errors == 0 && pts.pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hmtp_pkg.sv
hw/rtl/hmtp_parser.sv
hw/rtl/hmtp_thresh.sv
hw/rtl/height_map_text_parser_top.sv
hw/rtl/hmtp_checker.sv
tb/sv/tb_height_map_text_parser_top.sv
